// ----- sv/saa_pkg.sv -----
// ============================================================================
// saa_pkg - shared definitions for the systematic absence accumulator
// Field widths, bin numbering, payload layout, action codes and a helper
// for divisibility by three.
// ============================================================================
package saa_pkg;

    // Field widths
    localparam int INDEX_BITS     = 8;
    localparam int COUNT_BITS     = 24;
    localparam int INTEN_BITS     = 24;
    localparam int SIGMA_BITS     = 20;
    localparam int BIN_BITS       = 5;
    localparam int NUM_BINS       = 32;
    localparam int ISUM_BITS      = 48;
    localparam int SQSUM_BITS     = 64;
    localparam int OUT_COUNT_BITS = 24;
    localparam int ACTION_BITS    = 2;
    localparam int SQ_BITS        = 2 * SIGMA_BITS;

    // Sums of up to three indices need two extra bits.
    localparam int SUM_BITS  = INDEX_BITS + 2;
    // Width used by the divisibility-by-three fold; covers SUM_BITS up to 16.
    localparam int MOD3_BITS = 16;

    // Input payload layout, lowest bits first
    localparam int H_LSB         = 0;
    localparam int K_LSB         = INDEX_BITS;
    localparam int L_LSB         = 2 * INDEX_BITS;
    localparam int INTEN_LSB     = 3 * INDEX_BITS;
    localparam int SIGMA_LSB     = INTEN_LSB + INTEN_BITS;
    localparam int SEL_LSB       = SIGMA_LSB + SIGMA_BITS;
    localparam int IN_FIELD_BITS = SEL_LSB + BIN_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

    // Output payload layout
    localparam int OUT_FIELD_BITS = NUM_BINS + ISUM_BITS + SQSUM_BITS + OUT_COUNT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Lattice centrings, in bin order
    localparam int NUM_LATTICE   = 6;
    localparam int LAT_A         = 0;
    localparam int LAT_B         = 1;
    localparam int LAT_C         = 2;
    localparam int LAT_I         = 3;
    localparam int LAT_F         = 4;
    localparam int LAT_R         = 5;
    localparam int LAT_VIOL_BASE = 0;
    localparam int LAT_CONF_BASE = NUM_LATTICE;

    // Zone bins
    localparam int ZONE_0KL_B  = 12;
    localparam int ZONE_0KL_C  = 13;
    localparam int ZONE_0KL_N  = 14;
    localparam int ZONE_0KL_D  = 15;
    localparam int ZONE_H0L_A  = 16;
    localparam int ZONE_H0L_C  = 17;
    localparam int ZONE_H0L_N  = 18;
    localparam int ZONE_H0L_D  = 19;
    localparam int ZONE_HK0_B  = 20;
    localparam int ZONE_HK0_A  = 21;
    localparam int ZONE_HK0_N  = 22;
    localparam int ZONE_HK0_D  = 23;
    localparam int ZONE_H00_2  = 24;
    localparam int ZONE_0K0_2  = 25;
    localparam int ZONE_00L_2  = 26;
    localparam int ZONE_H00_4  = 27;
    localparam int ZONE_0K0_4  = 28;
    localparam int ZONE_00L_4  = 29;
    localparam int ZONE_00L_3  = 30;
    localparam int ZONE_00L_6  = 31;

    typedef logic signed [INDEX_BITS-1:0]     index_t;
    typedef logic signed [SUM_BITS-1:0]       sum_t;
    typedef logic signed [INTEN_BITS-1:0]     inten_t;
    typedef logic        [SIGMA_BITS-1:0]     sigma_t;
    typedef logic        [SQ_BITS-1:0]        sq_t;
    typedef logic signed [ISUM_BITS-1:0]      isum_t;
    typedef logic        [SQSUM_BITS-1:0]     sqsum_t;
    typedef logic        [COUNT_BITS-1:0]     count_t;
    typedef logic        [OUT_COUNT_BITS-1:0] out_count_t;
    typedef logic        [NUM_BINS-1:0]       bin_mask_t;
    typedef logic        [BIN_BITS-1:0]       bin_sel_t;
    typedef logic        [OUT_DATA_BITS-1:0]  out_data_t;
    typedef logic        [MOD3_BITS-1:0]      mod3_t;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ACCUM = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // True when v is not a multiple of three. Works on the magnitude by
    // summing base-4 digits, since 4 is congruent to 1 modulo 3.
    function automatic logic mod3_nonzero(input sum_t v);
        mod3_t      mag;
        logic [4:0] f1;
        logic [2:0] f2;
        logic [2:0] f3;
        mag = v[SUM_BITS-1] ? mod3_t'(-v) : mod3_t'(v);
        f1  = '0;
        for (int i = 0; i < MOD3_BITS / 2; i++)
        begin
            f1 = f1 + 5'(mag[2*i +: 2]);
        end
        f2 = 3'(f1[1:0]) + 3'(f1[3:2]) + 3'(f1[4]);
        f3 = 3'(f2[1:0]) + 3'(f2[2]);
        return !(f3 == 3'd0 || f3 == 3'd3);
    endfunction

endpackage

// ----- sv/systematic_absence_accumulator.sv -----
// ============================================================================
// systematic_absence_accumulator - absence statistics over 32 bins
// A taken beat waits in the input register, then is processed into the
// result register, which presents it. Throughput: one beat per cycle while
// the receiver does not stall; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset clears all 32 bins and the valid flags at once, leaving s_tready high.
// ============================================================================
module systematic_absence_accumulator
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Input stream. tuser: action.
    // tdata, lowest bit up: h_index, k_index, l_index, intensity, sigma,
    // bin_select, zero padding.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [saa_pkg::ACTION_BITS-1:0]   s_tuser,
    input  logic [saa_pkg::IN_DATA_BITS-1:0]  s_tdata,

    // Result stream.
    // tdata, lowest bit up: hit_mask, bin_intensity_sum, bin_sigma_sq_sum,
    // bin_count.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [saa_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    // ------------------------------------------------------------------
    // Input register. It holds one beat; the beat is processed in the
    // cycle that the result register can take its outcome.
    // ------------------------------------------------------------------
    logic                      in_valid_reg;
    logic [saa_pkg::ACTION_BITS-1:0] act_reg;
    saa_pkg::index_t           h_reg;
    saa_pkg::index_t           k_reg;
    saa_pkg::index_t           l_reg;
    saa_pkg::inten_t           inten_reg;
    saa_pkg::sigma_t           sigma_reg;
    saa_pkg::bin_sel_t         sel_reg;

    // Result register.
    logic                      out_valid_reg;
    saa_pkg::bin_mask_t        out_mask_reg;
    saa_pkg::isum_t            out_isum_reg;
    saa_pkg::sqsum_t           out_sqsum_reg;
    saa_pkg::out_count_t       out_count_reg;

    saa_pkg::bin_mask_t        out_mask_next;
    saa_pkg::isum_t            out_isum_next;
    saa_pkg::sqsum_t           out_sqsum_next;
    saa_pkg::out_count_t       out_count_next;

    // Bin store, one lane of registers per bin.
    saa_pkg::isum_t            isum_reg  [saa_pkg::NUM_BINS];
    saa_pkg::sqsum_t           sqsum_reg [saa_pkg::NUM_BINS];
    saa_pkg::count_t           cnt_reg   [saa_pkg::NUM_BINS];
    saa_pkg::isum_t            isum_next [saa_pkg::NUM_BINS];
    saa_pkg::sqsum_t           sqsum_next[saa_pkg::NUM_BINS];
    saa_pkg::count_t           cnt_next  [saa_pkg::NUM_BINS];

    logic                      advance;
    logic                      proc;
    saa_pkg::bin_mask_t        hit;
    saa_pkg::sq_t              sq;
    saa_pkg::sqsum_t           sq_ext;
    saa_pkg::isum_t            inten_ext;

    // The result register frees up when empty or when its beat is taken;
    // the input register frees up when empty or when its beat moves on.
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // ------------------------------------------------------------------
    // Classification. Divisibility by 2 and 4 needs only the low bits of
    // the two's complement value, which gives the same answer for negative
    // indices as for their magnitude.
    // ------------------------------------------------------------------
    function automatic saa_pkg::bin_mask_t classify(input saa_pkg::index_t h,
                                                    input saa_pkg::index_t k,
                                                    input saa_pkg::index_t l);
        saa_pkg::bin_mask_t m;
        saa_pkg::sum_t      hs;
        saa_pkg::sum_t      ks;
        saa_pkg::sum_t      ls;
        saa_pkg::sum_t      kl;
        saa_pkg::sum_t      hl;
        saa_pkg::sum_t      hk;
        saa_pkg::sum_t      rsum;
        logic               viol [saa_pkg::NUM_LATTICE];
        logic               hz;
        logic               kz;
        logic               lz;
        hs   = saa_pkg::sum_t'(h);
        ks   = saa_pkg::sum_t'(k);
        ls   = saa_pkg::sum_t'(l);
        kl   = ks + ls;
        hl   = hs + ls;
        hk   = hs + ks;
        rsum = ks + ls - hs;
        hz   = (h == '0);
        kz   = (k == '0);
        lz   = (l == '0);
        m    = '0;

        viol[saa_pkg::LAT_A] = kl[0];
        viol[saa_pkg::LAT_B] = hl[0];
        viol[saa_pkg::LAT_C] = hk[0];
        viol[saa_pkg::LAT_I] = hk[0] ^ l[0];
        viol[saa_pkg::LAT_F] = !((h[0] == k[0]) && (k[0] == l[0]));
        viol[saa_pkg::LAT_R] = saa_pkg::mod3_nonzero(rsum);
        for (int i = 0; i < saa_pkg::NUM_LATTICE; i++)
        begin
            m[saa_pkg::LAT_VIOL_BASE + i] = viol[i];
            m[saa_pkg::LAT_CONF_BASE + i] = !viol[i];
        end

        m[saa_pkg::ZONE_0KL_B] = hz && k[0];
        m[saa_pkg::ZONE_0KL_C] = hz && l[0];
        m[saa_pkg::ZONE_0KL_N] = hz && kl[0];
        m[saa_pkg::ZONE_0KL_D] = hz && (kl[1:0] != 2'b00);
        m[saa_pkg::ZONE_H0L_A] = kz && h[0];
        m[saa_pkg::ZONE_H0L_C] = kz && l[0];
        m[saa_pkg::ZONE_H0L_N] = kz && hl[0];
        m[saa_pkg::ZONE_H0L_D] = kz && (hl[1:0] != 2'b00);
        m[saa_pkg::ZONE_HK0_B] = lz && k[0];
        m[saa_pkg::ZONE_HK0_A] = lz && h[0];
        m[saa_pkg::ZONE_HK0_N] = lz && hk[0];
        m[saa_pkg::ZONE_HK0_D] = lz && (hk[1:0] != 2'b00);
        m[saa_pkg::ZONE_H00_2] = kz && lz && h[0];
        m[saa_pkg::ZONE_0K0_2] = hz && lz && k[0];
        m[saa_pkg::ZONE_00L_2] = hz && kz && l[0];
        m[saa_pkg::ZONE_H00_4] = kz && lz && (h[1:0] != 2'b00);
        m[saa_pkg::ZONE_0K0_4] = hz && lz && (k[1:0] != 2'b00);
        m[saa_pkg::ZONE_00L_4] = hz && kz && (l[1:0] != 2'b00);
        m[saa_pkg::ZONE_00L_3] = hz && kz && saa_pkg::mod3_nonzero(ls);
        // Not a multiple of six means odd or not a multiple of three.
        m[saa_pkg::ZONE_00L_6] = hz && kz && (l[0] || saa_pkg::mod3_nonzero(ls));
        return m;
    endfunction

    // Signed add that clamps to the intensity sum range.
    function automatic saa_pkg::isum_t sat_isum(input saa_pkg::isum_t a,
                                                input saa_pkg::isum_t b);
        logic [saa_pkg::ISUM_BITS:0] s;
        s = {a[saa_pkg::ISUM_BITS-1], a} + {b[saa_pkg::ISUM_BITS-1], b};
        if (s[saa_pkg::ISUM_BITS] != s[saa_pkg::ISUM_BITS-1])
        begin
            return s[saa_pkg::ISUM_BITS] ? {1'b1, {(saa_pkg::ISUM_BITS-1){1'b0}}}
                                         : {1'b0, {(saa_pkg::ISUM_BITS-1){1'b1}}};
        end
        return s[saa_pkg::ISUM_BITS-1:0];
    endfunction

    // Unsigned add that sticks at all ones.
    function automatic saa_pkg::sqsum_t sat_sqsum(input saa_pkg::sqsum_t a,
                                                  input saa_pkg::sqsum_t b);
        logic [saa_pkg::SQSUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[saa_pkg::SQSUM_BITS] ? '1 : s[saa_pkg::SQSUM_BITS-1:0];
    endfunction

    assign hit       = classify(h_reg, k_reg, l_reg);
    assign sq        = saa_pkg::sq_t'(sigma_reg) * saa_pkg::sq_t'(sigma_reg);
    assign sq_ext    = saa_pkg::sqsum_t'(sq);
    assign inten_ext = saa_pkg::isum_t'(inten_reg);

    // ------------------------------------------------------------------
    // Bin update and result selection
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int b = 0; b < saa_pkg::NUM_BINS; b++)
        begin
            isum_next[b]  = isum_reg[b];
            sqsum_next[b] = sqsum_reg[b];
            cnt_next[b]   = cnt_reg[b];
        end
        out_mask_next  = '0;
        out_isum_next  = '0;
        out_sqsum_next = '0;
        out_count_next = '0;

        if (proc)
        begin
            case (saa_pkg::action_t'(act_reg))
                saa_pkg::ACT_ACCUM:
                begin
                    out_mask_next = hit;
                    for (int b = 0; b < saa_pkg::NUM_BINS; b++)
                    begin
                        if (hit[b])
                        begin
                            isum_next[b]  = sat_isum(isum_reg[b], inten_ext);
                            sqsum_next[b] = sat_sqsum(sqsum_reg[b], sq_ext);
                            if (cnt_reg[b] != '1)
                            begin
                                cnt_next[b] = cnt_reg[b] + 1'b1;
                            end
                        end
                    end
                end
                saa_pkg::ACT_READ:
                begin
                    out_isum_next  = isum_reg[sel_reg];
                    out_sqsum_next = sqsum_reg[sel_reg];
                    out_count_next = saa_pkg::out_count_t'(cnt_reg[sel_reg]);
                end
                saa_pkg::ACT_CLEAR:
                begin
                    for (int b = 0; b < saa_pkg::NUM_BINS; b++)
                    begin
                        isum_next[b]  = '0;
                        sqsum_next[b] = '0;
                        cnt_next[b]   = '0;
                    end
                end
                default:
                begin
                    // Unused action code: nothing changes, the result is zero.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < saa_pkg::NUM_BINS; b++)
            begin
                isum_reg[b]  <= '0;
                sqsum_reg[b] <= '0;
                cnt_reg[b]   <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            for (int b = 0; b < saa_pkg::NUM_BINS; b++)
            begin
                isum_reg[b]  <= isum_next[b];
                sqsum_reg[b] <= sqsum_next[b];
                cnt_reg[b]   <= cnt_next[b];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg   <= s_tuser;
            h_reg     <= s_tdata[saa_pkg::H_LSB +: saa_pkg::INDEX_BITS];
            k_reg     <= s_tdata[saa_pkg::K_LSB +: saa_pkg::INDEX_BITS];
            l_reg     <= s_tdata[saa_pkg::L_LSB +: saa_pkg::INDEX_BITS];
            inten_reg <= s_tdata[saa_pkg::INTEN_LSB +: saa_pkg::INTEN_BITS];
            sigma_reg <= s_tdata[saa_pkg::SIGMA_LSB +: saa_pkg::SIGMA_BITS];
            sel_reg   <= s_tdata[saa_pkg::SEL_LSB +: saa_pkg::BIN_BITS];
        end
        if (proc)
        begin
            out_mask_reg  <= out_mask_next;
            out_isum_reg  <= out_isum_next;
            out_sqsum_reg <= out_sqsum_next;
            out_count_reg <= out_count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = saa_pkg::out_data_t'({out_count_reg, out_sqsum_reg,
                                            out_isum_reg, out_mask_reg});

`ifndef ASSERT_OFF
    // An accumulate result carries no bin contents.
    a_accum_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_mask_reg != '0)) |->
            (out_isum_reg == '0 && out_sqsum_reg == '0 && out_count_reg == '0))
        else $error("accumulate result carries bin contents");

    // Each centring lands in exactly one of its two lattice bins.
    a_lattice_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_mask_reg != '0)) |->
            ((out_mask_reg[saa_pkg::LAT_CONF_BASE-1:0] ^
              out_mask_reg[2*saa_pkg::NUM_LATTICE-1:saa_pkg::LAT_CONF_BASE]) == '1))
        else $error("lattice bins not complementary");

    // The count of bin 0 only drops when a clear action is processed.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc && act_reg == saa_pkg::ACT_CLEAR) |=>
            (cnt_reg[0] >= $past(cnt_reg[0])))
        else $error("bin count dropped without a clear");

    // With the result register empty the input side must be open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // A processed beat always shows up as a result beat in the next cycle.
    a_proc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid_reg)
        else $error("processed beat lost");
`endif

endmodule

// ----- verif/tb.sv -----
// ============================================================================
// tb - testbench for systematic_absence_accumulator
// Drives reflection, read, clear and unused-code beats into the input
// stream. Random gaps and stalls are applied on both streams. A scoreboard
// object keeps its own 32-bin statistics store. It works out the result
// beat for every accepted input beat and checks each result beat, field by
// field, against the oldest expected one.
// ============================================================================
module tb;

    import saa_pkg::*;

    // Action code 3 has no meaning; the block must answer it with zeros.
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

    // Result beat layout, lowest bits first
    localparam int OUT_ISUM_LSB  = NUM_BINS;
    localparam int OUT_SQSUM_LSB = OUT_ISUM_LSB + ISUM_BITS;
    localparam int OUT_COUNT_LSB = OUT_SQSUM_LSB + SQSUM_BITS;

    localparam longint ISUM_TOP    = (longint'(1) <<< (ISUM_BITS - 1)) - 1;
    localparam longint ISUM_BOTTOM = -ISUM_TOP - 1;

    localparam int RANDOM_BEATS = 1450;
    localparam int GAP_PERCENT  = 19;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the bin store plus the queue of result
    // beats that the block still owes.
    // ------------------------------------------------------------------------
    class absence_scoreboard;

        typedef struct {
            bin_mask_t  hits;
            isum_t      isum;
            sqsum_t     sqsum;
            out_count_t count;
        } result_t;

        longint    intensity_total [NUM_BINS];
        sqsum_t    sigma_sq_total [NUM_BINS];
        count_t    reflection_count [NUM_BINS];
        result_t   owed_results [$];
        int unsigned errors;

        function new();
            errors = 0;
            clear_bins();
        endfunction

        function void clear_bins();
            for (int b = 0; b < NUM_BINS; b++)
            begin
                intensity_total[b]  = 0;
                sigma_sq_total[b]   = '0;
                reflection_count[b] = '0;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Every mismatch prints one line and is counted.
        task report(string what);
            errors++;
            $display("tb: mismatch: %s", what);
        endtask

        // Bins that one reflection falls into. Divisibility is tested with
        // the sign kept, which classifies negative indices like positive
        // ones since a remainder is zero for both or for neither.
        function bin_mask_t absence_bins(int h, int k, int l);
            bin_mask_t              m;
            logic [NUM_LATTICE-1:0] viol;
            logic                   he;
            logic                   ke;
            logic                   le;
            m  = '0;
            he = (h % 2) == 0;
            ke = (k % 2) == 0;
            le = (l % 2) == 0;
            viol[LAT_A] = ((k + l) % 2) != 0;
            viol[LAT_B] = ((h + l) % 2) != 0;
            viol[LAT_C] = ((h + k) % 2) != 0;
            viol[LAT_I] = ((h + k + l) % 2) != 0;
            viol[LAT_F] = !((he && ke && le) || (!he && !ke && !le));
            viol[LAT_R] = ((-h + k + l) % 3) != 0;
            for (int i = 0; i < NUM_LATTICE; i++)
            begin
                if (viol[i])
                    m[LAT_VIOL_BASE + i] = 1'b1;
                else
                    m[LAT_CONF_BASE + i] = 1'b1;
            end
            if (h == 0)
            begin
                m[ZONE_0KL_B] = (k % 2) != 0;
                m[ZONE_0KL_C] = (l % 2) != 0;
                m[ZONE_0KL_N] = ((k + l) % 2) != 0;
                m[ZONE_0KL_D] = ((k + l) % 4) != 0;
            end
            if (k == 0)
            begin
                m[ZONE_H0L_A] = (h % 2) != 0;
                m[ZONE_H0L_C] = (l % 2) != 0;
                m[ZONE_H0L_N] = ((h + l) % 2) != 0;
                m[ZONE_H0L_D] = ((h + l) % 4) != 0;
            end
            if (l == 0)
            begin
                m[ZONE_HK0_B] = (k % 2) != 0;
                m[ZONE_HK0_A] = (h % 2) != 0;
                m[ZONE_HK0_N] = ((h + k) % 2) != 0;
                m[ZONE_HK0_D] = ((h + k) % 4) != 0;
            end
            if (k == 0 && l == 0)
            begin
                m[ZONE_H00_2] = (h % 2) != 0;
                m[ZONE_H00_4] = (h % 4) != 0;
            end
            if (h == 0 && l == 0)
            begin
                m[ZONE_0K0_2] = (k % 2) != 0;
                m[ZONE_0K0_4] = (k % 4) != 0;
            end
            if (h == 0 && k == 0)
            begin
                m[ZONE_00L_2] = (l % 2) != 0;
                m[ZONE_00L_4] = (l % 4) != 0;
                m[ZONE_00L_3] = (l % 3) != 0;
                m[ZONE_00L_6] = (l % 6) != 0;
            end
            return m;
        endfunction

        // Saturating update of one bin.
        function void add_to_bin(int b, inten_t inten, sq_t sq);
            longint                s;
            logic [SQSUM_BITS:0]   t;
            s = intensity_total[b] + longint'(inten);
            if (s > ISUM_TOP)
                s = ISUM_TOP;
            if (s < ISUM_BOTTOM)
                s = ISUM_BOTTOM;
            intensity_total[b] = s;
            t = {1'b0, sigma_sq_total[b]} + (SQSUM_BITS + 1)'(sq);
            sigma_sq_total[b] = t[SQSUM_BITS] ? '1 : t[SQSUM_BITS-1:0];
            if (reflection_count[b] != '1)
                reflection_count[b] = reflection_count[b] + 1'b1;
        endfunction

        // Called for every input beat the block accepts.
        function void note_beat(logic [ACTION_BITS-1:0] act,
                                logic [IN_DATA_BITS-1:0] data);
            result_t  r;
            index_t   h;
            index_t   k;
            index_t   l;
            inten_t   inten;
            sigma_t   sg;
            sq_t      sq;
            bin_sel_t sel;
            h     = data[H_LSB +: INDEX_BITS];
            k     = data[K_LSB +: INDEX_BITS];
            l     = data[L_LSB +: INDEX_BITS];
            inten = data[INTEN_LSB +: INTEN_BITS];
            sg    = data[SIGMA_LSB +: SIGMA_BITS];
            sel   = data[SEL_LSB +: BIN_BITS];
            r.hits  = '0;
            r.isum  = '0;
            r.sqsum = '0;
            r.count = '0;
            case (act)
                ACT_ACCUM:
                begin
                    sq     = sq_t'(sg) * sq_t'(sg);
                    r.hits = absence_bins(int'(h), int'(k), int'(l));
                    for (int b = 0; b < NUM_BINS; b++)
                    begin
                        if (r.hits[b])
                            add_to_bin(b, inten, sq);
                    end
                end
                ACT_READ:
                begin
                    r.isum  = isum_t'(intensity_total[sel]);
                    r.sqsum = sigma_sq_total[sel];
                    r.count = out_count_t'(reflection_count[sel]);
                end
                ACT_CLEAR:
                    clear_bins();
                default:
                    ;
            endcase
            owed_results.push_back(r);
        endfunction

        // Called for every result beat the block hands over.
        task check_beat(out_data_t d);
            result_t    r;
            bin_mask_t  hits;
            isum_t      isum;
            sqsum_t     sqsum;
            out_count_t count;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result beat %h with nothing pending", d));
                return;
            end
            r     = owed_results.pop_front();
            hits  = d[0 +: NUM_BINS];
            isum  = d[OUT_ISUM_LSB +: ISUM_BITS];
            sqsum = d[OUT_SQSUM_LSB +: SQSUM_BITS];
            count = d[OUT_COUNT_LSB +: OUT_COUNT_BITS];
            if (hits !== r.hits)
                report($sformatf("hit_mask %h, want %h", hits, r.hits));
            if (isum !== r.isum)
                report($sformatf("bin_intensity_sum %0d, want %0d", isum, r.isum));
            if (sqsum !== r.sqsum)
                report($sformatf("bin_sigma_sq_sum %0d, want %0d", sqsum, r.sqsum));
            if (count !== r.count)
                report($sformatf("bin_count %0d, want %0d", count, r.count));
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [ACTION_BITS-1:0]   s_tuser;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    out_data_t                m_tdata;

    absence_scoreboard board = new();

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    systematic_absence_accumulator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Both streams are watched at the rising edge, where the block's
    // registers still show their values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_beat(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            board.check_beat(m_tdata);
    end

    // Result side: the receiver stalls at random, except for one long
    // stretch where it takes every beat at once.
    initial
    begin
        int unsigned cycle;
        m_tready = 1'b0;
        cycle    = 0;
        forever
        begin
            @(negedge clk);
            cycle++;
            m_tready <= (cycle >= 1000 && cycle < 1600)
                        || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Hard limit on the whole run, far beyond the slowest correct run.
    initial
    begin
        #8000000;
        $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    bit steady_sender;

    function automatic logic [IN_DATA_BITS-1:0] pack_reflection(
        index_t h, index_t k, index_t l, inten_t inten, sigma_t sg, bin_sel_t sel);
        logic [IN_DATA_BITS-1:0] d;
        d = '0;
        d[H_LSB +: INDEX_BITS]     = h;
        d[K_LSB +: INDEX_BITS]     = k;
        d[L_LSB +: INDEX_BITS]     = l;
        d[INTEN_LSB +: INTEN_BITS] = inten;
        d[SIGMA_LSB +: SIGMA_BITS] = sg;
        d[SEL_LSB +: BIN_BITS]     = sel;
        return d;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // is taken. Valid is lowered only for a gap, so it never toggles twice
    // in one time step.
    task automatic send_beat(logic [ACTION_BITS-1:0] act, logic [IN_DATA_BITS-1:0] data);
        while (!steady_sender && $urandom_range(99) < GAP_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic accumulate(index_t h, index_t k, index_t l, inten_t inten, sigma_t sg);
        send_beat(ACT_ACCUM, pack_reflection(h, k, l, inten, sg, '0));
    endtask

    task automatic read_bin(bin_sel_t sel);
        send_beat(ACT_READ, pack_reflection('0, '0, '0, '0, '0, sel));
    endtask

    // Indices lean toward zero so the glide and screw zones get hit often.
    function automatic index_t pick_index();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3)
            return '0;
        else if (r < 6)
            return index_t'(int'($urandom_range(0, 24)) - 12);
        return index_t'($urandom);
    endfunction

    initial
    begin
        logic [ACTION_BITS-1:0] act;
        int unsigned            r;
        int                     taken;
        inten_t                 inten;
        sigma_t                 sg;
        bin_sel_t               probe [8];

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = '0;
        s_tdata       = '0;
        steady_sender = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Reads straight after reset must return an empty
        // store, then reflections go to the index and value extremes and to
        // each zone family.
        read_bin(5'd0);
        read_bin(5'd31);
        accumulate(8'sd0, 8'sd0, 8'sd0, 24'h7FFFFF, 20'hFFFFF);
        accumulate(8'sd1, 8'sd0, 8'sd0, 24'h800000, 20'hFFFFF);
        accumulate(8'sd0, 8'sd2, 8'sd0, 24'd16, 20'd1);
        accumulate(8'sd0, 8'sd0, 8'sd3, 24'hFFFFFF, 20'd16);
        accumulate(8'sd0, 8'sd0, -8'sd6, 24'd100, 20'd7);
        accumulate(8'sd0, 8'sd1, 8'sd2, -24'sd55, 20'd3);
        accumulate(8'sd2, 8'sd0, -8'sd1, 24'd9, 20'd2);
        accumulate(-8'sd1, 8'sd1, 8'sd0, 24'd5, 20'd5);
        accumulate(-8'sd128, 8'sd127, -8'sd128, 24'd0, 20'd0);
        accumulate(8'sd127, -8'sd128, 8'sd127, 24'h7FFFFF, 20'h80000);
        accumulate(8'sd1, 8'sd1, 8'sd1, 24'd32, 20'd4);
        accumulate(8'sd1, 8'sd2, 8'sd0, -24'sd1, 20'd8);
        // The unused action code with every payload bit set.
        send_beat(ACT_UNUSED, '1);
        probe = '{5'd0, 5'd6, 5'd11, 5'd12, 5'd24, 5'd27, 5'd30, 5'd31};
        foreach (probe[i])
            read_bin(probe[i]);
        send_beat(ACT_CLEAR, '0);
        read_bin(5'd6);
        read_bin(5'd31);

        // Random part. Reflections dominate; reads sample the bins as they
        // grow and occasional clears start the statistics over. Beats with
        // the unused code are sent too but are not counted.
        taken = 0;
        while (taken < RANDOM_BEATS)
        begin
            steady_sender = (taken >= 600 && taken < 900);
            r = $urandom_range(99);
            if (r < 72)
                act = ACT_ACCUM;
            else if (r < 94)
                act = ACT_READ;
            else if (r < 96)
                act = ACT_CLEAR;
            else
                act = ACT_UNUSED;
            inten = $urandom_range(1) ? inten_t'($urandom)
                                      : inten_t'(int'($urandom_range(0, 4000)) - 2000);
            sg    = $urandom_range(1) ? sigma_t'($urandom) : sigma_t'($urandom_range(0, 255));
            send_beat(act, pack_reflection(pick_index(), pick_index(), pick_index(),
                                           inten, sg, bin_sel_t'($urandom)));
            if (act != ACT_UNUSED)
                taken++;
        end
        steady_sender = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then keep watching the result stream so that any unexpected
        // extra beat would show.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- systematic_absence_accumulator.f -----
sv/saa_pkg.sv
sv/systematic_absence_accumulator.sv
verif/tb.sv
